/* hw/rtl/rpnb_pkg.sv */
// rpnb_pkg: shared types and constants for the nearest button box picker.
// Used by rpnb_div and ray_pick_nearest_button_box; depends on nothing.
package rpnb_pkg;

	localparam int MAX_BUTTONS = 16;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = 4;
	localparam int NUM_W       = 42;
	localparam int QW          = 32;

	localparam logic signed [QW-1:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] DIST_MIN = 32'sh8000_0000;
	localparam logic signed [QW-1:0] NEG_ONE  = -32'sd65536;

	typedef enum logic [2:0] {
		REG_OFFSET_X   = 3'd0,
		REG_OFFSET_Y   = 3'd1,
		REG_OFFSET_Z   = 3'd2,
		REG_ROW_DIR_X  = 3'd3,
		REG_ROW_DIR_Y  = 3'd4,
		REG_ROW_DIR_Z  = 3'd5,
		REG_PITCH      = 3'd6,
		REG_HALF_SIZE  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RP,
		S_MUL,
		S_CTR,
		S_NUM,
		S_DIV,
		S_ACC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [QW-1:0]    den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [QW-1:0] quot;
	} div_rsp_t;

endpackage

/* hw/rtl/ray_pick_nearest_button_box.sv */
// ray_pick_nearest_button_box: nearest button cube hit by a ray, slab test in Q16.16.
// Depends on rpnb_pkg and rpnb_div.
//
// Request channel: req_valid/req_stall carry the device origin, ray origin, ray direction
// and button count. A transaction is taken when req_valid is high and req_stall low;
// req_stall stays high from then until the result has been loaded into the response
// register. Response channel: rsp_valid/rsp_stall carry hit, button_index, hit_distance;
// the register holds while rsp_stall is high, and a new request may be taken meanwhile.
// Steps: row products for the three axes, then per button and axis the offset product,
// the slab bounds and two divisions through the one shared divider (both skipped when
// the direction component is zero), then the response load. A count of zero goes from
// the transaction straight to the response load. One request is in flight at a time;
// the next is taken the cycle after the response loads.
// Write registers over the APB port only while idle; pready is always high.
// Reset: asynchronous, active low; clears the sequencer and response valid and
// restores register defaults (row direction x = 1.0, all else 0).
module ray_pick_nearest_button_box (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [31:0] device_x,
	input  logic signed [31:0] device_y,
	input  logic signed [31:0] device_z,
	input  logic signed [31:0] ray_org_x,
	input  logic signed [31:0] ray_org_y,
	input  logic signed [31:0] ray_org_z,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	input  logic [4:0]         button_count,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               hit,
	output logic [3:0]         button_index,
	output logic [30:0]        hit_distance
);
	import rpnb_pkg::*;

	state_t state_q, state_d;

	logic signed [31:0] offset_q [3];
	logic signed [17:0] row_dir_q [3];
	logic [30:0]        pitch_q;
	logic [30:0]        half_q;

	logic signed [32:0] base_q [3];
	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic signed [49:0] rp_q [3];
	logic signed [55:0] prod_q;
	logic signed [40:0] lo_q, hi_q;
	logic signed [QW-1:0] l1_q, l2_q, lmin_q, lmax_q, best_q;
	logic               hit_q;
	logic [IDX_W-1:0]   idx_q;

	logic [CNT_W-1:0]   n_q, b_q;
	logic signed [5:0]  k_q;
	logic [1:0]         axis_q;
	logic               phase_q;

	logic               rsp_valid_q;
	logic               hit_out_q;
	logic [3:0]         idx_out_q;
	logic [30:0]        dist_out_q;

	logic [CNT_W-1:0]   n_sat;
	logic               accept;
	logic               out_free;
	logic               dir_zero;
	logic signed [39:0] ctr;
	logic signed [40:0] org_ext;
	logic signed [40:0] bound;
	logic signed [QW-1:0] new_min, new_max;
	logic               last_axis, last_button, cube_hit;
	reg_idx_t           widx;

	div_req_t div_req;
	div_rsp_t div_rsp;

	rpnb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign n_sat      = (button_count > CNT_W'(MAX_BUTTONS)) ? CNT_W'(MAX_BUTTONS) : button_count;
	assign accept     = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign dir_zero   = dir_q[axis_q] == 32'sd0;
	assign ctr        = {{7{base_q[axis_q][32]}}, base_q[axis_q]} + {prod_q[55], prod_q[55:17]};
	assign org_ext    = {{9{org_q[axis_q][31]}}, org_q[axis_q]};
	assign bound      = (phase_q ^ dir_q[axis_q][31]) ? hi_q : lo_q;
	assign new_min    = (l1_q > lmin_q) ? l1_q : lmin_q;
	assign new_max    = (l2_q < lmax_q) ? l2_q : lmax_q;
	assign last_axis  = axis_q == 2'd2;
	assign last_button = b_q == n_q - CNT_W'(1);
	assign cube_hit   = new_min < new_max;
	assign widx       = reg_idx_t'(paddr[4:2]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = (n_sat == '0) ? S_DONE : S_RP;
			S_RP:   if (last_axis) state_d = S_MUL;
			S_MUL:  state_d = S_CTR;
			S_CTR:  state_d = S_NUM;
			S_NUM:  state_d = dir_zero ? S_ACC : S_DIV;
			S_DIV:  if (div_rsp.done) state_d = phase_q ? S_ACC : S_NUM;
			S_ACC:  state_d = (last_axis && last_button) ? S_DONE : S_MUL;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall     = state_q != S_IDLE;
		div_req.start = state_q == S_NUM && !dir_zero;
		div_req.num   = NUM_W'(bound) - NUM_W'(org_ext);
		div_req.den   = dir_q[axis_q];
		pready        = 1'b1;
		rsp_valid     = rsp_valid_q;
		hit           = hit_out_q;
		button_index  = idx_out_q;
		hit_distance  = dist_out_q;
	end

	always_comb begin
		case (widx)
			REG_OFFSET_X:  prdata = offset_q[0];
			REG_OFFSET_Y:  prdata = offset_q[1];
			REG_OFFSET_Z:  prdata = offset_q[2];
			REG_ROW_DIR_X: prdata = {14'b0, row_dir_q[0]};
			REG_ROW_DIR_Y: prdata = {14'b0, row_dir_q[1]};
			REG_ROW_DIR_Z: prdata = {14'b0, row_dir_q[2]};
			REG_PITCH:     prdata = {1'b0, pitch_q};
			REG_HALF_SIZE: prdata = {1'b0, half_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q[0]  <= '0;
			offset_q[1]  <= '0;
			offset_q[2]  <= '0;
			row_dir_q[0] <= 18'sd65536;
			row_dir_q[1] <= '0;
			row_dir_q[2] <= '0;
			pitch_q      <= '0;
			half_q       <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_OFFSET_X:  offset_q[0]  <= pwdata;
				REG_OFFSET_Y:  offset_q[1]  <= pwdata;
				REG_OFFSET_Z:  offset_q[2]  <= pwdata;
				REG_ROW_DIR_X: row_dir_q[0] <= pwdata[17:0];
				REG_ROW_DIR_Y: row_dir_q[1] <= pwdata[17:0];
				REG_ROW_DIR_Z: row_dir_q[2] <= pwdata[17:0];
				REG_PITCH:     pitch_q      <= pwdata[30:0];
				REG_HALF_SIZE: half_q       <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			n_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			axis_q      <= '0;
			phase_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (accept) begin
					n_q    <= n_sat;
					b_q    <= '0;
					k_q    <= 6'sd1 - $signed({1'b0, n_sat});
					axis_q <= '0;
				end
				S_RP:  axis_q <= last_axis ? 2'd0 : axis_q + 2'd1;
				S_CTR: phase_q <= 1'b0;
				S_DIV: if (div_rsp.done) phase_q <= 1'b1;
				S_ACC: begin
					if (last_axis) begin
						axis_q <= '0;
						b_q    <= b_q + CNT_W'(1);
						k_q    <= k_q + 6'sd2;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				base_q[0] <= 33'(device_x) + 33'(offset_q[0]);
				base_q[1] <= 33'(device_y) + 33'(offset_q[1]);
				base_q[2] <= 33'(device_z) + 33'(offset_q[2]);
				org_q[0]  <= ray_org_x;
				org_q[1]  <= ray_org_y;
				org_q[2]  <= ray_org_z;
				dir_q[0]  <= ray_dir_x;
				dir_q[1]  <= ray_dir_y;
				dir_q[2]  <= ray_dir_z;
				best_q    <= DIST_MAX;
				hit_q     <= 1'b0;
				idx_q     <= '0;
				lmin_q    <= '0;
				lmax_q    <= DIST_MAX;
			end
			S_RP:  rp_q[axis_q] <= 50'(row_dir_q[axis_q]) * 50'($signed({1'b0, pitch_q}));
			S_MUL: prod_q <= 56'(rp_q[axis_q]) * 56'(k_q);
			S_CTR: begin
				lo_q <= 41'(ctr) - $signed({10'b0, half_q});
				hi_q <= 41'(ctr) + $signed({10'b0, half_q});
			end
			S_NUM: if (dir_zero) begin
				if (lo_q <= org_ext && org_ext < hi_q) begin
					l1_q <= '0;
					l2_q <= best_q;
				end else begin
					l1_q <= NEG_ONE;
					l2_q <= NEG_ONE;
				end
			end
			S_DIV: if (div_rsp.done) begin
				if (phase_q) l2_q <= div_rsp.quot;
				else         l1_q <= div_rsp.quot;
			end
			S_ACC: begin
				if (last_axis) begin
					lmin_q <= '0;
					if (cube_hit) begin
						best_q <= new_min;
						hit_q  <= 1'b1;
						idx_q  <= b_q[IDX_W-1:0];
						lmax_q <= new_min;
					end else begin
						lmax_q <= best_q;
					end
				end else begin
					lmin_q <= new_min;
					lmax_q <= new_max;
				end
			end
			S_DONE: if (out_free) begin
				hit_out_q  <= hit_q;
				idx_out_q  <= hit_q ? idx_q : 4'd0;
				dist_out_q <= best_q[30:0];
			end
			default: ;
		endcase
	end

	a_div_dir_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> !dir_zero) else $error("division on a zero direction");
	a_best_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !best_q[31]) else $error("best distance negative");
	a_hit_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE && hit_q |-> best_q != DIST_MAX) else $error("hit at max distance");
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q != 2'd3) else $error("axis counter out of range");

endmodule

/* hw/rtl/rpnb_div.sv */
// rpnb_div: shared radix-2 divider, Q16.16 quotient num*2^16/den, truncated, saturated.
// Depends on rpnb_pkg.
module rpnb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rpnb_pkg::div_req_t  req,
	output rpnb_pkg::div_rsp_t  rsp
);
	import rpnb_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [QW:0]       rem_q;
	logic [QW-1:0]     q_q;
	logic [QW-1:0]     dmag_q;
	logic              neg_q;
	logic              ovf_q;

	logic [NUM_W-1:0]  mag;
	logic [QW-1:0]     dmag;
	logic [25:0]       high;
	logic [QW:0]       trial;
	logic              ge;

	assign mag   = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign dmag  = req.den[QW-1] ? QW'(-req.den) : QW'(req.den);
	assign high  = mag[NUM_W-1:16];
	assign trial = {rem_q[QW-1:0], q_q[QW-1]};
	assign ge    = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dmag_q <= dmag;
			neg_q  <= req.num[NUM_W-1] ^ req.den[QW-1];
			ovf_q  <= {6'b0, high} >= dmag;
			rem_q  <= {7'b0, high};
			q_q    <= {mag[15:0], 16'h0};
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dmag_q}) : trial;
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (!neg_q) begin
			rsp.quot = (ovf_q || q_q[QW-1]) ? DIST_MAX : $signed(q_q);
		end else begin
			rsp.quot = (ovf_q || q_q > 32'h8000_0000) ? DIST_MIN : $signed(-q_q);
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q) else $error("done without a finished division");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == 5'd0 |=> done_q) else $error("division did not finish");

endmodule
